// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the ipv4 receive classifier rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: assertion failed");
// condition that must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("%m: forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== rtl/core/ipv4rc_pkg.sv =====
// types, codes and helpers of the ipv4 receive classifier
package ipv4rc_pkg;

	typedef enum logic [3:0] {
		VERDICT_BAD_CSUM       = 4'd0,
		VERDICT_BAD_LEN        = 4'd1,
		VERDICT_NET_UNREACH    = 4'd2,
		VERDICT_TTL_EXCEEDED   = 4'd3,
		VERDICT_FORWARD        = 4'd4,
		VERDICT_FRAGMENT       = 4'd5,
		VERDICT_UDP            = 4'd6,
		VERDICT_ICMP           = 4'd7,
		VERDICT_PROTO_UNREACH  = 4'd8
	} verdict_t;

	// configuration register indexes
	localparam logic [2:0] REG_LOCAL_ADDR_A  = 3'd0;
	localparam logic [2:0] REG_LOCAL_ADDR_B  = 3'd1;
	localparam logic [2:0] REG_LOCAL_ADDR_C  = 3'd2;
	localparam logic [2:0] REG_LOCAL_ADDR_D  = 3'd3;
	localparam logic [2:0] REG_ADDR_MASK     = 3'd4;
	localparam logic [2:0] REG_FORWARD_EN    = 3'd5;

	localparam logic [7:0] PROTO_UDP  = 8'h11;
	localparam logic [7:0] PROTO_ICMP = 8'h01;

	// header word positions that carry fields
	localparam logic [4:0] IDX_TOTAL_LEN = 5'd1;
	localparam logic [4:0] IDX_FRAG      = 5'd3;
	localparam logic [4:0] IDX_TTL_PROTO = 5'd4;
	localparam logic [4:0] IDX_CHECKSUM  = 5'd5;
	localparam logic [4:0] IDX_DEST_HI   = 5'd8;
	localparam logic [4:0] IDX_DEST_LO   = 5'd9;

	localparam logic [3:0] IHL_MIN = 4'd5;

	// configuration as seen by the decision logic
	typedef struct packed {
		logic [3:0][31:0] local_addr;
		logic [3:0]       addr_mask;
		logic             forward_en;
	} cfg_t;

	// header fields after the current word is folded in
	typedef struct packed {
		logic        short_ihl;
		logic [15:0] sum;
		logic [15:0] csum;
		logic [15:0] total_len;
		logic [15:0] frame;
		logic [15:0] ttl_proto;
		logic        frag;
		logic [31:0] dest;
		logic [5:0]  hdr_bytes;
	} hdr_t;

	// ones-complement add with end-around carry
	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage

// ===== rtl/core/ipv4rc_parse.sv =====
// header parser: per-word field capture and running checksum
module ipv4rc_parse
	import ipv4rc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  logic [15:0] word,
	input  logic        start,
	input  logic [15:0] frame,
	output hdr_t        hdr,
	output logic        done
);

	logic [4:0]  idx_q;
	logic [4:0]  hwc_q;
	logic [15:0] sum_q;
	logic [15:0] csum_q;
	logic [15:0] total_len_q;
	logic [15:0] frame_q;
	logic [15:0] ttl_proto_q;
	logic        frag_q;
	logic [31:0] dest_q;
	logic [5:0]  hdr_bytes_q;

	logic [3:0] ihl;
	logic       active;
	logic [4:0] idx_base;
	logic [4:0] hwc_base;
	logic [4:0] idx_next;
	hdr_t       base;

	assign ihl = word[11:8];

	// starting point: fresh header on start, else stored state
	always_comb begin
		base     = '0;
		idx_base = idx_q;
		hwc_base = hwc_q;
		active   = 1'b0;
		if (start) begin
			base.frame     = frame;
			base.hdr_bytes = {ihl, 2'b00};
			base.short_ihl = (ihl < IHL_MIN);
			idx_base       = '0;
			hwc_base       = (ihl < IHL_MIN) ? 5'd0 : {ihl, 1'b0};
			active         = 1'b1;
		end else begin
			base.sum       = sum_q;
			base.csum      = csum_q;
			base.total_len = total_len_q;
			base.frame     = frame_q;
			base.ttl_proto = ttl_proto_q;
			base.frag      = frag_q;
			base.dest      = dest_q;
			base.hdr_bytes = hdr_bytes_q;
			active         = (hwc_q != 5'd0);
		end
	end

	// fold the current word into the header fields
	always_comb begin
		hdr      = base;
		idx_next = idx_base + 5'd1;
		done     = 1'b0;
		if (base.short_ihl) begin
			done = 1'b1;
		end else if (active) begin
			case (idx_base)
				IDX_TOTAL_LEN: hdr.total_len = word;
				IDX_FRAG:      hdr.frag      = |word[13:0];
				IDX_TTL_PROTO: hdr.ttl_proto = word;
				IDX_CHECKSUM:  hdr.csum      = word;
				IDX_DEST_HI:   hdr.dest[31:16] = word;
				IDX_DEST_LO:   hdr.dest[15:0]  = word;
				default: ;
			endcase
			if (idx_base != IDX_TTL_PROTO && idx_base != IDX_CHECKSUM) begin
				hdr.sum = oc_add(base.sum, word);
			end
			done = (idx_next >= hwc_base);
		end
	end

	// control state: position and expected word count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			hwc_q <= '0;
		end else if (fire && active) begin
			if (done) begin
				idx_q <= '0;
				hwc_q <= '0;
			end else begin
				idx_q <= idx_next;
				hwc_q <= hwc_base;
			end
		end
	end

	// header field registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			csum_q      <= '0;
			total_len_q <= '0;
			frame_q     <= '0;
			ttl_proto_q <= '0;
			frag_q      <= 1'b0;
			dest_q      <= '0;
			hdr_bytes_q <= '0;
		end else if (fire && active) begin
			sum_q       <= hdr.sum;
			csum_q      <= hdr.csum;
			total_len_q <= hdr.total_len;
			frame_q     <= hdr.frame;
			ttl_proto_q <= hdr.ttl_proto;
			frag_q      <= hdr.frag;
			dest_q      <= hdr.dest;
			hdr_bytes_q <= hdr.hdr_bytes;
		end
	end

endmodule

// ===== rtl/core/ipv4rc_decide.sv =====
// verdict logic: checksum, length, address match and forward rewrite
module ipv4rc_decide
	import ipv4rc_pkg::*;
#(
	parameter int LOCAL_SLOTS = 4
) (
	input  hdr_t        hdr,
	input  cfg_t        cfg,
	output verdict_t    verdict,
	output logic [7:0]  new_ttl,
	output logic [15:0] new_checksum,
	output logic [15:0] payload_size
);

	logic [7:0]  ttl;
	logic [7:0]  ttl_dec;
	logic [15:0] ours;
	logic [15:0] fwd_csum;
	logic        is_local;
	logic [15:0] hb_ext;

	assign ttl      = hdr.ttl_proto[15:8];
	assign ttl_dec  = ttl - 8'd1;
	assign ours     = ~oc_add(hdr.sum, hdr.ttl_proto);
	assign fwd_csum = ~oc_add(hdr.sum, {ttl_dec, hdr.ttl_proto[7:0]});
	assign hb_ext   = {10'd0, hdr.hdr_bytes};

	// payload bytes, saturating at zero
	assign payload_size = (hdr.frame > hb_ext) ? (hdr.frame - hb_ext) : 16'd0;

	// destination match against enabled local slots
	always_comb begin
		is_local = 1'b0;
		for (int i = 0; i < LOCAL_SLOTS; i++) begin
			if (cfg.addr_mask[i] && cfg.local_addr[i] == hdr.dest) begin
				is_local = 1'b1;
			end
		end
	end

	// verdict in priority order
	always_comb begin
		verdict      = VERDICT_PROTO_UNREACH;
		new_ttl      = '0;
		new_checksum = '0;
		if (hdr.short_ihl) begin
			verdict = VERDICT_BAD_LEN;
		end else if (ours != hdr.csum) begin
			verdict = VERDICT_BAD_CSUM;
		end else if (hdr.total_len > hdr.frame) begin
			verdict = VERDICT_BAD_LEN;
		end else if (!is_local) begin
			if (!cfg.forward_en) begin
				verdict = VERDICT_NET_UNREACH;
			end else if (ttl <= 8'd1) begin
				verdict = VERDICT_TTL_EXCEEDED;
			end else begin
				verdict      = VERDICT_FORWARD;
				new_ttl      = ttl_dec;
				new_checksum = fwd_csum;
			end
		end else if (hdr.frag) begin
			verdict = VERDICT_FRAGMENT;
		end else if (hdr.ttl_proto[7:0] == PROTO_UDP) begin
			verdict = VERDICT_UDP;
		end else if (hdr.ttl_proto[7:0] == PROTO_ICMP) begin
			verdict = VERDICT_ICMP;
		end
	end

endmodule

// ===== rtl/core/ipv4_receive_classifier.sv =====
// ipv4 receive classifier top level: input stage, parser, decision, result register
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  in      | input     | in_valid/in_stall  | header_word, start_of_header, frame_size
//  out     | output    | out_valid/out_stall| verdict, new_ttl, new_checksum, payload_size
//  cfg     | input     | cfg_write          | cfg_index, cfg_data
//
// one header word per cycle while in_stall is low; the word that ends the header passes through
// the input register, then parse and decide logic into the result register, to give a verdict.
// asynchronous active-low reset clears configuration, parser state and both valid flags.
// a stalled result holds the result register; the input stage then fills and stalls in turn.
module ipv4_receive_classifier
	import ipv4rc_pkg::*;
#(
	parameter int LOCAL_SLOTS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] header_word,
	input  logic        start_of_header,
	input  logic [15:0] frame_size,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  verdict,
	output logic [7:0]  new_ttl,
	output logic [15:0] new_checksum,
	output logic [15:0] payload_size,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

`include "assert_macros.svh"

	cfg_t        cfg_q;
	logic        valid_s1;
	logic [15:0] word_s1;
	logic        start_s1;
	logic [15:0] frame_s1;
	logic        advance;
	logic        fire;
	hdr_t        hdr;
	logic        done;
	verdict_t    dec_verdict;
	logic [7:0]  dec_ttl;
	logic [15:0] dec_csum;
	logic [15:0] dec_payload;
	logic        out_valid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_LOCAL_ADDR_A: cfg_q.local_addr[0] <= cfg_data;
				REG_LOCAL_ADDR_B: cfg_q.local_addr[1] <= cfg_data;
				REG_LOCAL_ADDR_C: cfg_q.local_addr[2] <= cfg_data;
				REG_LOCAL_ADDR_D: cfg_q.local_addr[3] <= cfg_data;
				REG_ADDR_MASK:    cfg_q.addr_mask     <= cfg_data[3:0];
				REG_FORWARD_EN:   cfg_q.forward_en    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// pipeline moves when the result register is free or being taken
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign fire     = valid_s1 && advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			word_s1  <= header_word;
			start_s1 <= start_of_header;
			frame_s1 <= frame_size;
		end
	end

	ipv4rc_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.word   (word_s1),
		.start  (start_s1),
		.frame  (frame_s1),
		.hdr    (hdr),
		.done   (done)
	);

	ipv4rc_decide #(
		.LOCAL_SLOTS (LOCAL_SLOTS)
	) u_decide (
		.hdr          (hdr),
		.cfg          (cfg_q),
		.verdict      (dec_verdict),
		.new_ttl      (dec_ttl),
		.new_checksum (dec_csum),
		.payload_size (dec_payload)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire && done;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && done) begin
			verdict      <= dec_verdict;
			new_ttl      <= dec_ttl;
			new_checksum <= dec_csum;
			payload_size <= dec_payload;
		end
	end

	assign out_valid = out_valid_q;

	// rewrite fields are only nonzero on a forward word
	`ASSERT_PROP(a_rewrite_only_fwd, clk, arst_n,
		(out_valid && verdict != VERDICT_FORWARD) |-> (new_ttl == 8'd0 && new_checksum == 16'd0))
	// a forwarded word never leaves with an expired ttl
	`ASSERT_NEVER(a_fwd_ttl_live, clk, arst_n,
		out_valid && verdict == VERDICT_FORWARD && new_ttl == 8'd0)
	// the input side stalls only while a word sits in the input stage behind a held result
	`ASSERT_PROP(a_stall_cause, clk, arst_n,
		in_stall |-> (valid_s1 && out_valid_q && out_stall))

endmodule

// ===== test/tb_top.sv =====
// self-checking testbench for the ipv4 receive classifier: header streams, verdict scoreboard
module tb_top;
	import ipv4rc_pkg::*;

	localparam int CLK_PERIOD = 8;
	localparam int RESET_CYCLES = 9;
	localparam int LOCAL_SLOTS = 4;
	localparam int SETTLE_CYCLES = 8;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_OFF_CYCLES = 300;

	// one expected verdict word
	typedef struct packed {
		verdict_t    verdict;
		logic [7:0]  ttl;
		logic [15:0] checksum;
		logic [15:0] payload;
	} verdict_rec_t;

	// header parser model plus the queue of verdicts it predicts
	class verdict_scoreboard;
		logic [31:0]  local_addr [LOCAL_SLOTS];
		logic [3:0]   addr_mask;
		logic         fwd_en;
		logic [4:0]   word_idx;
		logic [4:0]   hdr_words;
		logic [15:0]  sum;
		logic [15:0]  rx_csum;
		logic [15:0]  tot_len;
		logic [15:0]  frame;
		logic [15:0]  ttl_proto;
		logic         frag;
		logic [31:0]  dest;
		logic [5:0]   hdr_bytes;
		verdict_rec_t expected_verdicts [$];
		int           kind_count [9];
		int           n_checked;
		int           n_errors;

		function new();
			foreach (local_addr[i]) local_addr[i] = '0;
			foreach (kind_count[i]) kind_count[i] = 0;
			addr_mask = '0;
			fwd_en = 1'b0;
			word_idx = '0;
			hdr_words = '0;
			sum = '0;
			rx_csum = '0;
			tot_len = '0;
			frame = '0;
			ttl_proto = '0;
			frag = 1'b0;
			dest = '0;
			hdr_bytes = '0;
			n_checked = 0;
			n_errors = 0;
		endfunction

		// ones-complement 16-bit add, carry folded back in
		static function logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
			int unsigned t;
			t = 32'(a) + 32'(b);
			return 16'(t + (t >> 16));
		endfunction

		function void set_reg(input logic [2:0] idx, input logic [31:0] data);
			case (idx)
				REG_LOCAL_ADDR_A: local_addr[0] = data;
				REG_LOCAL_ADDR_B: local_addr[1] = data;
				REG_LOCAL_ADDR_C: local_addr[2] = data;
				REG_LOCAL_ADDR_D: local_addr[3] = data;
				REG_ADDR_MASK: addr_mask = data[3:0];
				REG_FORWARD_EN: fwd_en = data[0];
				default: ;
			endcase
		endfunction

		// queue a verdict and return the parser to idle
		function void push_verdict(input verdict_t v, input logic [7:0] t, input logic [15:0] c);
			verdict_rec_t r;
			r.verdict = v;
			r.ttl = t;
			r.checksum = c;
			r.payload = (frame > {10'd0, hdr_bytes}) ? frame - {10'd0, hdr_bytes} : 16'd0;
			expected_verdicts.push_back(r);
			kind_count[v]++;
			hdr_words = '0;
			word_idx = '0;
		endfunction

		// verdict after the last header word
		function void decide();
			logic [7:0]  ttl;
			logic [7:0]  proto;
			logic [7:0]  dec_ttl;
			logic        is_ours;
			ttl = ttl_proto[15:8];
			proto = ttl_proto[7:0];
			is_ours = 1'b0;
			for (int i = 0; i < LOCAL_SLOTS; i++)
				if (addr_mask[i] && local_addr[i] == dest) is_ours = 1'b1;
			if (~fold_add(sum, ttl_proto) != rx_csum)
				push_verdict(VERDICT_BAD_CSUM, 8'd0, 16'd0);
			else if (tot_len > frame)
				push_verdict(VERDICT_BAD_LEN, 8'd0, 16'd0);
			else if (!is_ours) begin
				if (!fwd_en)
					push_verdict(VERDICT_NET_UNREACH, 8'd0, 16'd0);
				else if (ttl <= 8'd1)
					push_verdict(VERDICT_TTL_EXCEEDED, 8'd0, 16'd0);
				else begin
					dec_ttl = ttl - 8'd1;
					push_verdict(VERDICT_FORWARD, dec_ttl, ~fold_add(sum, {dec_ttl, proto}));
				end
			end else if (frag)
				push_verdict(VERDICT_FRAGMENT, 8'd0, 16'd0);
			else if (proto == PROTO_UDP)
				push_verdict(VERDICT_UDP, 8'd0, 16'd0);
			else if (proto == PROTO_ICMP)
				push_verdict(VERDICT_ICMP, 8'd0, 16'd0);
			else
				push_verdict(VERDICT_PROTO_UNREACH, 8'd0, 16'd0);
		endfunction

		// fold one accepted input word into the parser
		function void note_word(input logic [15:0] w, input logic s, input logic [15:0] f);
			logic [3:0] ihl;
			ihl = w[11:8];
			if (s) begin
				frame = f;
				hdr_bytes = {ihl, 2'b00};
				word_idx = '0;
				sum = '0;
				rx_csum = '0;
				tot_len = '0;
				ttl_proto = '0;
				frag = 1'b0;
				dest = '0;
				if (ihl < IHL_MIN) begin
					push_verdict(VERDICT_BAD_LEN, 8'd0, 16'd0);
					return;
				end
				hdr_words = {ihl, 1'b0};
			end else if (hdr_words == 5'd0) begin
				return;
			end
			case (word_idx)
				IDX_TOTAL_LEN: tot_len = w;
				IDX_FRAG: frag = (w[13:0] != 14'd0);
				IDX_TTL_PROTO: ttl_proto = w;
				IDX_CHECKSUM: rx_csum = w;
				IDX_DEST_HI: dest[31:16] = w;
				IDX_DEST_LO: dest[15:0] = w;
				default: ;
			endcase
			if (word_idx != IDX_TTL_PROTO && word_idx != IDX_CHECKSUM) sum = fold_add(sum, w);
			word_idx = word_idx + 5'd1;
			if (word_idx >= hdr_words) decide();
		endfunction

		// compare one accepted verdict with the oldest prediction
		function void check_verdict(input logic [3:0] v, input logic [7:0] t,
				input logic [15:0] c, input logic [15:0] p);
			verdict_rec_t e;
			if (expected_verdicts.size() == 0) begin
				$error("verdict %0d arrived with none expected", v);
				n_errors++;
				return;
			end
			e = expected_verdicts.pop_front();
			n_checked++;
			if (v != e.verdict) begin
				$error("verdict: expected %0d, got %0d", e.verdict, v);
				n_errors++;
			end
			if (t != e.ttl) begin
				$error("new_ttl: expected %0d, got %0d", e.ttl, t);
				n_errors++;
			end
			if (c != e.checksum) begin
				$error("new_checksum: expected %h, got %h", e.checksum, c);
				n_errors++;
			end
			if (p != e.payload) begin
				$error("payload_size: expected %0d, got %0d", e.payload, p);
				n_errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [15:0] header_word = '0;
	logic        start_of_header = 1'b0;
	logic [15:0] frame_size = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  verdict;
	logic [7:0]  new_ttl;
	logic [15:0] new_checksum;
	logic [15:0] payload_size;
	logic        cfg_write = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	verdict_scoreboard sb = new();

	int          send_gap_pct = 31;
	int          recv_gap_pct = 64;
	int          hold_cycles = 0;
	int          quiet_cycles = 0;
	int          words_in = 0;
	int          n_settings = 0;
	logic [31:0] addr_pool [LOCAL_SLOTS];
	logic [15:0] hdr_buf [30];
	logic [15:0] hdr_frame;
	int          hdr_len;

	ipv4_receive_classifier dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.header_word(header_word),
		.start_of_header(start_of_header),
		.frame_size(frame_size),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.verdict(verdict),
		.new_ttl(new_ttl),
		.new_checksum(new_checksum),
		.payload_size(payload_size),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// receiver: random stalls, or a long hold-off when one is requested
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles = hold_cycles - 1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_gap_pct);
		end
	end

	// accepted words into the model, accepted verdicts against it, watchdog on quiet cycles
	always @(posedge clk) begin
		if (arst_n) begin
			quiet_cycles++;
			if (in_valid && !in_stall) begin
				sb.note_word(header_word, start_of_header, frame_size);
				words_in++;
				quiet_cycles = 0;
			end
			if (out_valid && !out_stall) begin
				sb.check_verdict(verdict, new_ttl, new_checksum, payload_size);
				quiet_cycles = 0;
			end
			if (cfg_write) quiet_cycles = 0;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// offer one word at a falling edge, return at the falling edge after it is taken
	task automatic send_word(input logic [15:0] w, input logic s, input logic [15:0] f);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		header_word <= w;
		start_of_header <= s;
		frame_size <= f;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.set_reg(idx, data);
		@(negedge clk);
	endtask

	task automatic program_cfg(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c,
			input logic [31:0] d, input logic [3:0] mask, input logic fwd);
		write_reg(REG_LOCAL_ADDR_A, a);
		write_reg(REG_LOCAL_ADDR_B, b);
		write_reg(REG_LOCAL_ADDR_C, c);
		write_reg(REG_LOCAL_ADDR_D, d);
		write_reg(REG_ADDR_MASK, {28'd0, mask});
		write_reg(REG_FORWARD_EN, {31'd0, fwd});
		cfg_write <= 1'b0;
		addr_pool[0] = a;
		addr_pool[1] = b;
		addr_pool[2] = c;
		addr_pool[3] = d;
		n_settings++;
	endtask

	// well-formed header with a correct or damaged checksum
	task automatic build_header(input logic [3:0] ihl, input logic [15:0] frame,
			input logic [15:0] total, input logic [15:0] frag_word, input logic [7:0] ttl,
			input logic [7:0] proto, input logic [31:0] dst, input logic corrupt);
		logic [15:0] acc;
		hdr_len = 2 * int'(ihl);
		for (int i = 0; i < hdr_len; i++) hdr_buf[i] = 16'($urandom);
		hdr_buf[0] = {($urandom_range(0, 99) < 80) ? 4'h4 : 4'($urandom), ihl, 8'($urandom)};
		hdr_buf[IDX_TOTAL_LEN] = total;
		hdr_buf[IDX_FRAG] = frag_word;
		hdr_buf[IDX_TTL_PROTO] = {ttl, proto};
		hdr_buf[IDX_DEST_HI] = dst[31:16];
		hdr_buf[IDX_DEST_LO] = dst[15:0];
		acc = '0;
		for (int i = 0; i < hdr_len; i++)
			if (i != int'(IDX_CHECKSUM)) acc = verdict_scoreboard::fold_add(acc, hdr_buf[i]);
		hdr_buf[IDX_CHECKSUM] = ~acc ^ (corrupt ? 16'($urandom_range(1, 65535)) : 16'd0);
		hdr_frame = frame;
	endtask

	task automatic send_header(input int n);
		for (int i = 0; i < n; i++)
			send_word(hdr_buf[i], i == 0, (i == 0) ? hdr_frame : 16'($urandom));
	endtask

	// mostly well-formed headers, plus truncations, stray words and short ihl starts
	task automatic random_segment(input int n_words);
		int          sent;
		int          roll;
		int          cut;
		int          hb;
		logic [3:0]  ihl;
		logic [15:0] frame;
		logic [15:0] total;
		logic [15:0] frag_word;
		logic [7:0]  ttl;
		logic [7:0]  proto;
		logic [31:0] dst;
		sent = 0;
		while (sent < n_words) begin
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				// stray words: dropped while idle, else they extend a cut header
				repeat ($urandom_range(1, 3)) send_word(16'($urandom), 1'b0, 16'($urandom));
			end else if (roll < 15) begin
				send_word({4'($urandom), 4'($urandom_range(0, 4)), 8'($urandom)}, 1'b1,
					16'($urandom));
				sent++;
			end else begin
				cut = $urandom_range(0, 99);
				ihl = (cut < 70) ? 4'd5 : (cut < 90) ? 4'($urandom_range(6, 8)) :
					4'($urandom_range(9, 15));
				hb = 4 * int'(ihl);
				cut = $urandom_range(0, 99);
				if (cut < 75) frame = 16'(hb + int'($urandom_range(0, 1500)));
				else if (cut < 90) frame = 16'($urandom);
				else frame = 16'($urandom_range(0, hb));
				cut = $urandom_range(0, 99);
				if (cut < 15) total = frame;
				else if (cut < 85 || frame == 16'hffff)
					total = 16'($urandom_range(0, int'(frame)));
				else total = 16'($urandom_range(int'(frame) + 1, 65535));
				frag_word = ($urandom_range(0, 99) < 55) ? {2'($urandom), 14'd0} : 16'($urandom);
				cut = $urandom_range(0, 99);
				ttl = (cut < 10) ? 8'd0 : (cut < 20) ? 8'd1 : (cut < 30) ? 8'd2 :
					(cut < 40) ? 8'hff : 8'($urandom);
				cut = $urandom_range(0, 99);
				proto = (cut < 35) ? PROTO_UDP : (cut < 60) ? PROTO_ICMP : 8'($urandom);
				cut = $urandom_range(0, 99);
				if (cut < 55) dst = addr_pool[$urandom_range(0, LOCAL_SLOTS - 1)];
				else if (cut < 70) dst = ($urandom_range(0, 1) != 0) ? 32'hffffffff : 32'd0;
				else dst = $urandom;
				build_header(ihl, frame, total, frag_word, ttl, proto, dst,
					$urandom_range(0, 99) < 12);
				cut = (roll < 25) ? int'($urandom_range(1, hdr_len - 1)) : hdr_len;
				send_header(cut);
				sent += cut;
			end
		end
	endtask

	// close with a short ihl start so the parser is idle, then let every verdict drain
	task automatic end_segment();
		send_word({4'h4, 4'($urandom_range(0, 4)), 8'($urandom)}, 1'b1, 16'($urandom));
		in_valid <= 1'b0;
		while (sb.expected_verdicts.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: ignored word, short ihl extremes, restart mid header, forward, local icmp
		program_cfg(32'hc0a80001, 32'h0a000001, 32'hffffffff, 32'h00000000, 4'b0111, 1'b1);
		send_word(16'hffff, 1'b0, 16'hffff);
		send_word({4'h4, 4'h0, 8'h00}, 1'b1, 16'hffff);
		send_word({4'hf, 4'h4, 8'hff}, 1'b1, 16'h0000);
		build_header(4'd5, 16'd100, 16'd60, 16'h0000, 8'd64, PROTO_UDP, 32'hc0a80001, 1'b0);
		send_header(3);
		build_header(4'd5, 16'hffff, 16'hffff, 16'h4000, 8'hff, 8'h06, 32'h00000000, 1'b0);
		send_header(hdr_len);
		build_header(4'd5, 16'd20, 16'd20, 16'h0000, 8'd1, PROTO_ICMP, 32'hffffffff, 1'b0);
		send_header(hdr_len);
		end_segment();

		// all slots live, forwarding on; receiver holds off midway
		program_cfg($urandom, $urandom, $urandom, $urandom, 4'hf, 1'b1);
		random_segment(150);
		hold_cycles = HOLD_OFF_CYCLES;
		random_segment(150);
		end_segment();

		// swap idle rates, forwarding off
		send_gap_pct = 64;
		recv_gap_pct = 31;
		program_cfg($urandom, $urandom, $urandom, $urandom, 4'b0101, 1'b0);
		random_segment(300);
		end_segment();

		// full rate on both sides
		send_gap_pct = 0;
		recv_gap_pct = 0;
		program_cfg(32'h00000000, 32'hffffffff, $urandom, $urandom, 4'b1010, 1'b1);
		random_segment(200);
		end_segment();
		program_cfg($urandom, $urandom, $urandom, $urandom, 4'h0, 1'b1);
		random_segment(100);
		end_segment();

		$display("run: %0d header words accepted, %0d verdicts checked, %0d register settings",
			words_in, sb.n_checked, n_settings);
		$display("verdicts csum %0d len %0d unreach %0d ttl %0d fwd %0d ",
			sb.kind_count[VERDICT_BAD_CSUM], sb.kind_count[VERDICT_BAD_LEN],
			sb.kind_count[VERDICT_NET_UNREACH], sb.kind_count[VERDICT_TTL_EXCEEDED],
			sb.kind_count[VERDICT_FORWARD],
			"frag %0d udp %0d icmp %0d proto %0d",
			sb.kind_count[VERDICT_FRAGMENT], sb.kind_count[VERDICT_UDP],
			sb.kind_count[VERDICT_ICMP], sb.kind_count[VERDICT_PROTO_UNREACH]);
		if (sb.n_errors == 0 && sb.expected_verdicts.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
